>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the port allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UPA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("port allocator assertion failed");
`define UPA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("port allocator assertion failed");
`else
`define UPA_ASSERT(lbl, clk, rst_n, prop)
`define UPA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> src/upa_pkg.sv
// ----------------------------------------------------------------------------
// upa_pkg
// Types and constants of the UDP port allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package upa_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] ip_addr;
    logic [15:0] port;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_port;
  } rsp_t;

  // Request modes.
  localparam logic [1:0] MODE_CLAIM = 2'd0;
  localparam logic [1:0] MODE_EPHEM = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_USED    = 2'd1;
  localparam logic [1:0] ST_NO_IF   = 2'd2;
  localparam logic [1:0] ST_EXHAUST = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_IFACE_COUNT = 3'd0;
  localparam logic [2:0] CFG_IFACE_ADDR0 = 3'd1;
  localparam logic [2:0] CFG_IFACE_ADDR3 = 3'd4;

  localparam int NUM_ADDR_REGS = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  // Ephemeral range, in ports and in 64-bit bitmap words.
  localparam logic [15:0] EPH_LOW     = 16'd49152;
  localparam logic [9:0]  EPH_WORD_LO = 10'd768;
  localparam logic [9:0]  EPH_WORD_HI = 10'd1023;
  localparam logic [8:0]  EPH_WORDS   = 9'd256;

  typedef struct packed {
    logic clear;
    logic load_req;
    logic lookup;
    logic read;
    logic advance;
    logic commit;
  } upa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic skip;
    logic done;
    logic out_free;
  } upa_sts_t;

endpackage

`default_nettype wire

>>> src/upa_ctrl.sv
// ----------------------------------------------------------------------------
// upa_ctrl
// Sequencer of the port allocator: clearing pass, lookup, bitmap reads and
// result commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module upa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire upa_pkg::upa_sts_t sts_i,
  output upa_pkg::upa_cmd_t      cmd_o
);
  import upa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_READ,
    S_CHECK
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt        = state_r;
    cmd_o            = '0;
    cmd_o.clear      = (state_r == S_CLEAR);
    cmd_o.load_req   = (state_r == S_IDLE) && in_valid;
    cmd_o.lookup     = (state_r == S_LOOKUP);
    cmd_o.read       = (state_r == S_READ);
    case (state_r)
      S_CLEAR: begin
        if (sts_i.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_nxt = sts_i.skip ? S_CHECK : S_READ;
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.done) begin
          // The result waits here until the output register can take it.
          if (sts_i.out_free) begin
            cmd_o.commit = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd_o.advance = 1'b1;
          state_nxt     = S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `UPA_ASSERT(a_commit_free, clk, rst_n, cmd_o.commit |-> sts_i.out_free)
  `UPA_ASSERT(a_accept_lookup, clk, rst_n, cmd_o.load_req |=> (state_r == S_LOOKUP))
  `UPA_ASSERT(a_advance_not_done, clk, rst_n, cmd_o.advance |-> !sts_i.done)

endmodule

`default_nettype wire

>>> src/upa_dp.sv
// ----------------------------------------------------------------------------
// upa_dp
// Datapath of the port allocator: configuration registers, interface match,
// bitmap memory, free-bit search, next-port registers and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module upa_dp #(
  parameter int NUM_IFACES = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire upa_pkg::req_t                  in_data,
  input  wire logic                           cfg_wr_en,
  input  wire logic [upa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [upa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire upa_pkg::upa_cmd_t              cmd_i,
  output upa_pkg::upa_sts_t                   sts_o,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output upa_pkg::rsp_t                       out_data
);
  import upa_pkg::*;

  localparam int IFW   = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
  localparam int AW    = IFW + 10;
  localparam int DEPTH = NUM_IFACES * 1024;
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  // Configuration.
  logic [2:0]  iface_count_r;
  logic [31:0] iface_addr_r [NUM_ADDR_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iface_count_r <= '0;
      for (int i = 0; i < NUM_ADDR_REGS; i++) iface_addr_r[i] <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_IFACE_COUNT) begin
        iface_count_r <= cfg_wdata[2:0];
      end else if (cfg_index >= CFG_IFACE_ADDR0 && cfg_index <= CFG_IFACE_ADDR3) begin
        iface_addr_r[2'(cfg_index - CFG_IFACE_ADDR0)] <= cfg_wdata;
      end
    end
  end

  // Request and search state.
  req_t           req_r;
  logic           found_r;
  logic [IFW-1:0] ifc_r;
  logic [9:0]     word_r;
  logic [5:0]     off_r;
  logic [8:0]     vis_r;
  logic [15:0]    next_port_r [NUM_IFACES];

  logic           match_found;
  logic [IFW-1:0] match_ifc;
  logic [15:0]    start_port;

  // Lowest matching interface among those counted in use.
  always_comb begin
    match_found = 1'b0;
    match_ifc   = '0;
    for (int i = NUM_IFACES - 1; i >= 0; i--) begin
      if (3'(i) < iface_count_r && iface_addr_r[i] == req_r.ip_addr) begin
        match_found = 1'b1;
        match_ifc   = IFW'(i);
      end
    end
  end

  assign start_port = (next_port_r[match_ifc] < EPH_LOW) ? EPH_LOW : next_port_r[match_ifc];

  always_ff @(posedge clk) begin
    if (cmd_i.load_req) req_r <= in_data;
    if (cmd_i.lookup) begin
      found_r <= match_found;
      ifc_r   <= match_ifc;
      vis_r   <= '0;
      if (req_r.mode == MODE_EPHEM) begin
        word_r <= start_port[15:6];
        off_r  <= start_port[5:0];
      end else begin
        word_r <= req_r.port[15:6];
        off_r  <= req_r.port[5:0];
      end
    end else if (cmd_i.advance) begin
      vis_r  <= vis_r + 9'd1;
      word_r <= (word_r == EPH_WORD_HI) ? EPH_WORD_LO : word_r + 10'd1;
    end
  end

  // Bitmap memory with a clearing pass after reset.
  logic [63:0]   mem [DEPTH];
  logic [63:0]   rdata_r;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] acc_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;

  assign acc_addr = {ifc_r, word_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.read) rdata_r <= mem[acc_addr];
  end

  // Word evaluation.
  logic [63:0] low_mask;
  logic [63:0] eph_view;
  logic        has_zero;
  logic [5:0]  zero_idx;
  logic [63:0] port_bit;
  logic        done;
  logic        wr_need;
  logic [63:0] upd_word;
  logic        np_upd;
  rsp_t        result;

  assign low_mask = (64'd1 << off_r) - 64'd1;
  // Ports below the start point count as used on the first word only.
  assign eph_view = (vis_r == 9'd0) ? (rdata_r | low_mask) : rdata_r;
  assign port_bit = 64'd1 << off_r;

  always_comb begin
    has_zero = 1'b0;
    zero_idx = '0;
    for (int i = 63; i >= 0; i--) begin
      if (!eph_view[i]) begin
        has_zero = 1'b1;
        zero_idx = 6'(i);
      end
    end
  end

  always_comb begin
    done     = 1'b1;
    wr_need  = 1'b0;
    upd_word = rdata_r;
    np_upd   = 1'b0;
    result   = '{status: ST_OK, granted_port: 16'd0};
    if (req_r.mode == MODE_NOP) begin
      result.status = ST_OK;
    end else if (!found_r) begin
      result.status = ST_NO_IF;
    end else begin
      case (req_r.mode)
        MODE_CLAIM: begin
          if ((rdata_r & port_bit) != 64'd0) begin
            result.status = ST_USED;
          end else begin
            wr_need             = 1'b1;
            upd_word            = rdata_r | port_bit;
            result.granted_port = req_r.port;
          end
        end
        MODE_EPHEM: begin
          if (has_zero) begin
            wr_need             = 1'b1;
            np_upd              = 1'b1;
            upd_word            = rdata_r | (64'd1 << zero_idx);
            result.granted_port = {word_r, zero_idx};
          end else if (vis_r == EPH_WORDS) begin
            result.status = ST_EXHAUST;
          end else begin
            done = 1'b0;
          end
        end
        MODE_FREE: begin
          wr_need  = 1'b1;
          upd_word = rdata_r & ~port_bit;
        end
        default: result.status = ST_OK;
      endcase
    end
  end

  assign mem_we    = cmd_i.clear || (cmd_i.commit && wr_need);
  assign mem_waddr = cmd_i.clear ? clr_cnt_r : acc_addr;
  assign mem_wdata = cmd_i.clear ? 64'd0 : upd_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_IFACES; i++) next_port_r[i] <= '0;
    end else if (cmd_i.commit && np_upd) begin
      next_port_r[ifc_r] <= {word_r, zero_idx};
    end
  end

  // Output register.
  logic out_valid_r;
  rsp_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.commit) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts_o.clr_last = (clr_cnt_r == CLR_LAST);
  assign sts_o.skip     = (req_r.mode == MODE_NOP) || !match_found;
  assign sts_o.done     = done;
  assign sts_o.out_free = !out_valid_r || !out_stall;

  `UPA_ASSERT(a_out_from_commit, clk, rst_n, $rose(out_valid_r) |-> $past(cmd_i.commit))
  `UPA_ASSERT(a_scan_bounded, clk, rst_n, cmd_i.advance |-> (vis_r < EPH_WORDS))
  `UPA_ASSERT(a_clear_quiet, clk, rst_n, cmd_i.clear |-> !out_valid_r)

endmodule

`default_nettype wire

>>> src/udp_port_allocator.sv
// ----------------------------------------------------------------------------
// udp_port_allocator
// Per-interface UDP port allocator over a used-port bitmap.
// ----------------------------------------------------------------------------
// After reset the bitmap memory is zeroed one 64-bit word per cycle, all
// NUM_IFACES*1024 words (4096 by default); no item is taken meanwhile,
// though configuration writes are. An item then runs through lookup, a
// bitmap read and a check for a claim of a given port or a free, through
// lookup and the check alone for an unknown address or the no-op mode, and
// through lookup and then a read and a check per word for an ephemeral claim
// that scans W bitmap words (W from 1 to 257). Each word costs one read of
// the single-port bitmap memory and one check of the 64 bits it returns. A
// new item is accepted while the previous result still sits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module udp_port_allocator #(
  parameter int NUM_IFACES = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire upa_pkg::req_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output upa_pkg::rsp_t                       out_data,
  input  wire logic                           cfg_wr_en,
  input  wire logic [upa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [upa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import upa_pkg::*;

  upa_cmd_t cmd;
  upa_sts_t sts;

  upa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  upa_dp #(
    .NUM_IFACES (NUM_IFACES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> tb/tb_udp_port_allocator.sv
// ----------------------------------------------------------------------------
// tb_udp_port_allocator
// Self-checking bench for the UDP port allocator. A scoreboard keeps its own
// per-interface port bitmaps and next-port registers, predicts the status and
// granted port of every accepted request and compares them with the results
// in order. Stimulus runs through directed claims, frees and ephemeral
// claims, a run of ephemeral claims on one interface across several bitmap
// words, and random requests under several interface settings, with random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_udp_port_allocator;
  import upa_pkg::*;

  localparam int          NUM_IFACES   = 4;
  localparam int          EPH_SPAN     = 16384;
  localparam int          FILL_ITEMS   = 256;
  localparam int          PHASE_ITEMS  = 355;
  localparam int unsigned CYCLE_LIMIT  = 6_000_000;
  localparam logic [31:0] ADDR_A       = 32'h0000_0000;
  localparam logic [31:0] ADDR_B       = 32'hFFFF_FFFF;
  localparam logic [31:0] ADDR_C       = 32'hC0A8_0001;
  localparam logic [31:0] ADDR_D       = 32'h0A00_0001;

  class alloc_scoreboard;
    logic [2:0]  iface_count;
    logic [31:0] iface_addr [NUM_IFACES];
    bit          used_map [NUM_IFACES][65536];
    logic [15:0] next_port [NUM_IFACES];
    rsp_t        grant_q [$];
    int          mismatches;

    function new();
      iface_count = '0;
      foreach (iface_addr[i]) begin
        iface_addr[i] = '0;
        next_port[i]  = '0;
      end
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_IFACE_COUNT) begin
        iface_count = data[2:0];
      end else if (idx >= CFG_IFACE_ADDR0 && idx <= CFG_IFACE_ADDR3) begin
        iface_addr[idx - CFG_IFACE_ADDR0] = data;
      end
    endfunction

    // The lowest matching index among the interfaces in use wins.
    function int lookup_iface(logic [31:0] addr);
      int limit;
      int hit;
      limit = (iface_count > NUM_IFACES) ? NUM_IFACES : int'(iface_count);
      hit = -1;
      for (int i = limit - 1; i >= 0; i--) begin
        if (iface_addr[i] == addr) hit = i;
      end
      return hit;
    endfunction

    function void note_request(req_t r);
      rsp_t        exp;
      int          ifc;
      int unsigned p;
      bit          found;
      exp.status       = ST_OK;
      exp.granted_port = '0;
      if (r.mode != MODE_NOP) begin
        ifc = lookup_iface(r.ip_addr);
        if (ifc < 0) begin
          exp.status = ST_NO_IF;
        end else if (r.mode == MODE_CLAIM) begin
          if (used_map[ifc][r.port]) begin
            exp.status = ST_USED;
          end else begin
            used_map[ifc][r.port] = 1'b1;
            exp.granted_port = r.port;
          end
        end else if (r.mode == MODE_EPHEM) begin
          // The search starts at the last port handed out and wraps once
          // around the ephemeral range.
          p = (next_port[ifc] < EPH_LOW) ? 32'(EPH_LOW) : 32'(next_port[ifc]);
          found = 1'b0;
          exp.status = ST_EXHAUST;
          for (int k = 0; k < EPH_SPAN && !found; k++) begin
            if (!used_map[ifc][p]) begin
              used_map[ifc][p] = 1'b1;
              next_port[ifc] = 16'(p);
              exp.granted_port = 16'(p);
              exp.status = ST_OK;
              found = 1'b1;
            end else begin
              p = (p == 32'hFFFF) ? 32'(EPH_LOW) : p + 1;
            end
          end
        end else if (r.mode == MODE_FREE) begin
          used_map[ifc][r.port] = 1'b0;
        end
      end
      grant_q.push_back(exp);
    endfunction

    function void flag(string what, rsp_t exp, rsp_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s: expected status %0d port %0d, got status %0d port %0d",
                 $realtime, what, exp.status, exp.granted_port, got.status,
                 got.granted_port);
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp;
      if (grant_q.size() == 0) begin
        flag("result with no request pending", '0, got);
      end else begin
        exp = grant_q.pop_front();
        if (got.status !== exp.status) flag("status mismatch", exp, got);
        else if (got.granted_port !== exp.granted_port) flag("port mismatch", exp, got);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  req_t                  in_data;
  logic                  out_valid;
  logic                  out_stall;
  rsp_t                  out_data;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  alloc_scoreboard sb;
  int              in_gap_max;
  int              out_gap_max;
  int unsigned     cycle_count;

  udp_port_allocator #(
    .NUM_IFACES(NUM_IFACES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic req_t make_req(logic [1:0] mode, logic [31:0] addr, logic [15:0] port);
    req_t r;
    r.mode    = mode;
    r.ip_addr = addr;
    r.port    = port;
    return r;
  endfunction

  // Mostly configured addresses and ports clustered at the edges of the
  // ephemeral range, so that claims, frees and searches run into each other.
  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    r.mode = (pick < 35) ? MODE_CLAIM : (pick < 60) ? MODE_EPHEM :
             (pick < 95) ? MODE_FREE : MODE_NOP;
    if ($urandom_range(0, 4) == 0) r.ip_addr = $urandom;
    else r.ip_addr = sb.iface_addr[$urandom_range(0, NUM_IFACES - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 40) r.port = EPH_LOW + 16'($urandom_range(0, 127));
    else if (pick < 55) r.port = 16'hFFFF - 16'($urandom_range(0, 127));
    else if (pick < 75) r.port = 16'($urandom_range(0, 127));
    else r.port = 16'($urandom);
    return r;
  endfunction

  task automatic send_request(req_t r);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.grant_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [2:0] count, logic [31:0] a0, logic [31:0] a1,
                           logic [31:0] a2, logic [31:0] a3);
    logic [31:0]           addrs [NUM_IFACES];
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    addrs[0] = a0;
    addrs[1] = a1;
    addrs[2] = a2;
    addrs[3] = a3;
    wait_drained();
    for (int i = 0; i <= NUM_IFACES; i++) begin
      if (i == 0) begin
        idx  = CFG_IFACE_COUNT;
        data = 32'(count);
      end else begin
        idx  = CFG_IFACE_ADDR0 + 3'(i - 1);
        data = addrs[i - 1];
      end
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= data;
      @(posedge clk);
      sb.write_reg(idx, data);
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Result side: a random stall before each item is taken.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      out_stall <= (hold > 0);
      if (hold > 0) hold--;
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result(out_data);
        hold = $urandom_range(0, out_gap_max);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[udp_port_allocator] ERROR");
    $finish;
  end

  initial begin
    sb = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_gap_max  = 6;
    out_gap_max = 6;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // With no interface in use, every address is unknown.
    send_request(make_req(MODE_CLAIM, ADDR_A, 16'd0));
    send_request(make_req(MODE_NOP, ADDR_A, 16'd0));

    configure(3'd4, ADDR_A, ADDR_B, ADDR_C, ADDR_D);
    send_request(make_req(MODE_CLAIM, ADDR_A, 16'd0));
    send_request(make_req(MODE_CLAIM, ADDR_A, 16'd0));
    send_request(make_req(MODE_CLAIM, ADDR_A, 16'hFFFF));
    send_request(make_req(MODE_FREE, ADDR_A, 16'd0));
    send_request(make_req(MODE_FREE, ADDR_A, 16'd0));
    send_request(make_req(MODE_CLAIM, ADDR_A, 16'd0));
    send_request(make_req(MODE_EPHEM, ADDR_A, 16'h0000));
    send_request(make_req(MODE_EPHEM, ADDR_A, 16'hFFFF));
    send_request(make_req(MODE_CLAIM, ADDR_A, EPH_LOW + 16'd2));
    send_request(make_req(MODE_EPHEM, ADDR_A, 16'h5A5A));
    send_request(make_req(MODE_FREE, ADDR_A, EPH_LOW));
    send_request(make_req(MODE_EPHEM, ADDR_A, 16'hA5A5));
    send_request(make_req(MODE_CLAIM, 32'h1234_5678, 16'd80));
    send_request(make_req(MODE_FREE, 32'hEDCB_A987, 16'd80));
    send_request(make_req(MODE_NOP, ADDR_B, 16'hFFFF));
    send_request(make_req(MODE_CLAIM, ADDR_B, 16'hFFFF));
    send_request(make_req(MODE_CLAIM, ADDR_D, EPH_LOW));
    send_request(make_req(MODE_EPHEM, ADDR_D, 16'd0));
    send_request(make_req(MODE_EPHEM, ADDR_C, 16'd0));

    // Hand out a run of ephemeral ports of one interface back to back,
    // across several bitmap words, then reopen two ports.
    in_gap_max  = 0;
    out_gap_max = 0;
    for (int n = 0; n < FILL_ITEMS; n++) begin
      send_request(make_req(MODE_EPHEM, ADDR_B, 16'($urandom)));
    end
    in_gap_max  = 6;
    out_gap_max = 6;
    send_request(make_req(MODE_CLAIM, ADDR_B, 16'd50000));
    send_request(make_req(MODE_FREE, ADDR_B, 16'hFFFF));
    send_request(make_req(MODE_FREE, ADDR_B, 16'd49300));
    send_request(make_req(MODE_EPHEM, ADDR_B, 16'd0));
    send_request(make_req(MODE_EPHEM, ADDR_B, 16'd0));
    send_request(make_req(MODE_EPHEM, ADDR_B, 16'd0));

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: configure(3'd4, ADDR_A, ADDR_B, ADDR_C, ADDR_D);
        1: configure(3'd7, ADDR_C, ADDR_B, ADDR_C, ADDR_B);
        2: configure(3'd1, $urandom, ADDR_B, ADDR_A, $urandom);
        3: configure(3'd3, $urandom, ADDR_B, $urandom, ADDR_A);
        default: configure(3'd0, ADDR_A, ADDR_B, ADDR_C, ADDR_D);
      endcase
      for (int n = 0; n < ((ph == 4) ? 50 : PHASE_ITEMS); n++) begin
        // Mix stretches of random gaps with stretches at full rate, chosen at random.
        if (n % 50 == 0) begin
          in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 6;
          out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
        end
        if ($urandom_range(0, 199) == 0) wait_drained();
        send_request(random_request());
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.grant_q.size() == 0) begin
      $display("[udp_port_allocator] OK");
    end else begin
      $display("[udp_port_allocator] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/upa_pkg.sv
src/upa_ctrl.sv
src/upa_dp.sv
src/udp_port_allocator.sv
tb/tb_udp_port_allocator.sv
